// ===== rtl/core/rgb_led_serial_transmitter_assert.svh =====
// ----------------------------------------------------------------------------
// RGB LED serial transmitter assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_SERIAL_TRANSMITTER_ASSERT_SVH
`define RGB_LED_SERIAL_TRANSMITTER_ASSERT_SVH

// same-cycle implication
`define RGBLS_ASSERT_IMP(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("rgbls assertion failed");

// next-cycle implication
`define RGBLS_ASSERT_NXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("rgbls assertion failed");

`endif

// ===== rtl/core/rgbls_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB LED serial transmitter package
// Types, codes and constants shared by the transmitter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbls_pkg;

  localparam int CHAIN_LENGTH_DEF = 3;

  localparam int OP_W       = 2;
  localparam int INDEX_W    = 8;
  localparam int COLOR_W    = 24;
  localparam int TIME_W     = 10;
  localparam int CNT_W      = 16;
  localparam int BIT_PTR_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [BIT_PTR_W-1:0] LAST_BIT = 5'd23;

  localparam logic [TIME_W-1:0] ZERO_HIGH_RST = 10'd40;
  localparam logic [TIME_W-1:0] ZERO_LOW_RST  = 10'd85;
  localparam logic [TIME_W-1:0] ONE_HIGH_RST  = 10'd80;
  localparam logic [TIME_W-1:0] ONE_LOW_RST   = 10'd45;
  localparam logic [CNT_W-1:0]  LATCH_RST     = 16'd6000;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 2'd0,
    OP_WRITE_ONE = 2'd1,
    OP_WRITE_ALL = 2'd2,
    OP_RESERVED  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_HIGH = 3'd0,
    CFG_ZERO_LOW  = 3'd1,
    CFG_ONE_HIGH  = 3'd2,
    CFG_ONE_LOW   = 3'd3,
    CFG_LATCH     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_WRITE_ONE = 2'd1,
    CMD_WRITE_ALL = 2'd2,
    CMD_WRITE_BAD = 2'd3
  } cmd_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [INDEX_W-1:0] led_index;
    logic [COLOR_W-1:0] grb_color;
  } in_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic write_refused;
    logic frame_done;
  } out_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [INDEX_W-1:0] led_index;
    logic [COLOR_W-1:0] grb_color;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_led_serial_transmitter.sv =====
// Throughput: one request per cycle while the queue has room and no clearing
// pass runs; a two-entry queue feeds the timing engine, and each popped request
// is registered as its result. Reset: timing registers return to defaults and
// a clearing pass zeroes the color store, with in_ready low until it ends.
// ----------------------------------------------------------------------------
// RGB LED serial transmitter
// Drives a daisy chain of serial RGB LEDs from a stored GRB color per LED.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_serial_transmitter import rgbls_pkg::*; #(
  parameter int CHAIN_LENGTH = CHAIN_LENGTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t       q_cmd;
  logic       q_valid;
  logic       q_pop;
  bk_status_t status;
  cfg_wr_t    cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  rgbls_front #(
    .CHAIN_LENGTH(CHAIN_LENGTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .status  (status),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  rgbls_back #(
    .CHAIN_LENGTH(CHAIN_LENGTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .status   (status),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rgbls_ram.sv =====
// ----------------------------------------------------------------------------
// RGB LED serial transmitter RAM
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbls_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 3,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/rgbls_front.sv =====
// ----------------------------------------------------------------------------
// RGB LED serial transmitter front end
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbls_front import rgbls_pkg::*; #(
  parameter int CHAIN_LENGTH = CHAIN_LENGTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_t        in_data,
  input  wire bk_status_t status,
  output logic            q_valid,
  output cmd_t            q_cmd,
  input  wire logic       q_pop
);

  localparam int IW = ($clog2(CHAIN_LENGTH + 1) > INDEX_W) ?
                      $clog2(CHAIN_LENGTH + 1) : INDEX_W;
  localparam logic [IW-1:0] CHAIN_END = IW'(CHAIN_LENGTH);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;
  logic       idx_ok;

  assign idx_ok = IW'(in_data.led_index) < CHAIN_END;

  always_comb begin
    cmd_in.led_index = in_data.led_index;
    cmd_in.grb_color = in_data.grb_color;
    unique case (in_data.opcode)
      OP_WRITE_ONE: cmd_in.kind = idx_ok ? CMD_WRITE_ONE : CMD_WRITE_BAD;
      OP_WRITE_ALL: cmd_in.kind = CMD_WRITE_ALL;
      default:      cmd_in.kind = CMD_TICK;
    endcase
  end

  assign in_ready = (count != 2'd2) && !status.clearing;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rgbls_back.sv =====
// ----------------------------------------------------------------------------
// RGB LED serial transmitter back end
// Color store, bit timing engine, configuration and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbls_back import rgbls_pkg::*; #(
  parameter int CHAIN_LENGTH = CHAIN_LENGTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_wr_t cfg,
  input  wire logic    q_valid,
  input  wire cmd_t    q_cmd,
  output logic         q_pop,
  output bk_status_t   status,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_t         out_data
);

  localparam int AW = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
  localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
  localparam logic [AW-1:0] LAST_LED = AW'(CHAIN_LENGTH - 1);
  localparam bit MULTI = (CHAIN_LENGTH > 1);

  logic [TIME_W-1:0] zero_high;
  logic [TIME_W-1:0] zero_low;
  logic [TIME_W-1:0] one_high;
  logic [TIME_W-1:0] one_low;
  logic [CNT_W-1:0]  latch_len;

  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     cycle_counter, cycle_counter_next;
  logic [BIT_PTR_W-1:0] bit_pointer, bit_pointer_next;
  logic [AW-1:0]        led_pointer, led_pointer_next;
  logic [COLOR_W-1:0]   shift_word, shift_word_next;
  logic [COLOR_W-1:0]   led0_color, led0_color_next;

  logic               sweep_on, sweep_on_next;
  logic [AW-1:0]      sweep_idx, sweep_idx_next;
  logic [COLOR_W-1:0] sweep_data, sweep_data_next;
  logic               clearing, clearing_next;

  logic               single_we;
  logic [AW-1:0]      idx_addr;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COLOR_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [COLOR_W-1:0] ram_rdata;

  logic              bit_val;
  logic [TIME_W-1:0] hi_sel, lo_sel;
  logic [CNT_W-1:0]  hi_len, lo_len, lt_len, cnt_inc;
  logic [IW-1:0]     idx_ext;
  out_t              res;

  assign idx_ext  = IW'(q_cmd.led_index);
  assign idx_addr = idx_ext[AW-1:0];

  assign bit_val = shift_word[COLOR_W-1];
  assign hi_sel  = bit_val ? one_high : zero_high;
  assign lo_sel  = bit_val ? one_low : zero_low;
  assign hi_len  = (hi_sel == '0) ? CNT_W'(1) : CNT_W'(hi_sel);
  assign lo_len  = (lo_sel == '0) ? CNT_W'(1) : CNT_W'(lo_sel);
  assign lt_len  = (latch_len == '0) ? CNT_W'(1) : latch_len;
  assign cnt_inc = cycle_counter + CNT_W'(1);

  assign q_pop           = q_valid && (!out_valid || out_ready);
  assign status.clearing = clearing;

  assign ram_we    = sweep_on || single_we;
  assign ram_waddr = sweep_on ? sweep_idx : idx_addr;
  assign ram_wdata = sweep_on ? sweep_data : q_cmd.grb_color;
  assign ram_raddr = (led_pointer == LAST_LED) ? '0 : led_pointer + AW'(1);

  rgbls_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(CHAIN_LENGTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    phase_next         = phase;
    cycle_counter_next = cycle_counter;
    bit_pointer_next   = bit_pointer;
    led_pointer_next   = led_pointer;
    shift_word_next    = shift_word;
    led0_color_next    = led0_color;
    sweep_on_next      = sweep_on;
    sweep_idx_next     = sweep_idx;
    sweep_data_next    = sweep_data;
    clearing_next      = clearing;
    single_we          = 1'b0;
    res                = '0;

    if (sweep_on) begin
      if (sweep_idx == LAST_LED) begin
        sweep_on_next = 1'b0;
        clearing_next = 1'b0;
      end else begin
        sweep_idx_next = sweep_idx + AW'(1);
      end
    end

    if (q_pop) begin
      if (phase != PH_IDLE) begin
        res.busy_res      = 1'b1;
        res.write_refused = (q_cmd.kind != CMD_TICK);
        unique case (phase)
          PH_HIGH: begin
            res.line_level     = 1'b1;
            cycle_counter_next = cnt_inc;
            if (cnt_inc >= hi_len) begin
              cycle_counter_next = '0;
              phase_next         = PH_LOW;
            end
          end
          PH_LOW: begin
            cycle_counter_next = cnt_inc;
            if (cnt_inc >= lo_len) begin
              cycle_counter_next = '0;
              phase_next         = PH_HIGH;
              if (bit_pointer >= LAST_BIT) begin
                bit_pointer_next = '0;
                if (led_pointer == LAST_LED) begin
                  led_pointer_next = '0;
                  shift_word_next  = '0;
                  phase_next       = PH_LATCH;
                end else begin
                  led_pointer_next = led_pointer + AW'(1);
                  shift_word_next  = ram_rdata;
                end
              end else begin
                bit_pointer_next = bit_pointer + BIT_PTR_W'(1);
                shift_word_next  = {shift_word[COLOR_W-2:0], 1'b0};
              end
            end
          end
          PH_LATCH: begin
            cycle_counter_next = cnt_inc;
            if (cnt_inc >= lt_len) begin
              cycle_counter_next = '0;
              phase_next         = PH_IDLE;
              res.frame_done     = 1'b1;
            end
          end
          PH_IDLE: begin
          end
        endcase
      end else begin
        unique case (q_cmd.kind)
          CMD_WRITE_BAD: begin
            res.write_refused = 1'b1;
          end
          CMD_WRITE_ONE, CMD_WRITE_ALL: begin
            res.busy_res       = 1'b1;
            phase_next         = PH_HIGH;
            cycle_counter_next = '0;
            bit_pointer_next   = '0;
            led_pointer_next   = '0;
            if (q_cmd.kind == CMD_WRITE_ALL) begin
              led0_color_next = q_cmd.grb_color;
              shift_word_next = q_cmd.grb_color;
              if (MULTI) begin
                sweep_on_next   = 1'b1;
                sweep_idx_next  = AW'(1);
                sweep_data_next = q_cmd.grb_color;
              end
            end else if (idx_addr == '0) begin
              led0_color_next = q_cmd.grb_color;
              shift_word_next = q_cmd.grb_color;
            end else begin
              single_we       = 1'b1;
              shift_word_next = led0_color;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      cycle_counter <= '0;
      bit_pointer   <= '0;
      led_pointer   <= '0;
      shift_word    <= '0;
      led0_color    <= '0;
      sweep_on      <= 1'b1;
      sweep_idx     <= '0;
      sweep_data    <= '0;
      clearing      <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      cycle_counter <= cycle_counter_next;
      bit_pointer   <= bit_pointer_next;
      led_pointer   <= led_pointer_next;
      shift_word    <= shift_word_next;
      led0_color    <= led0_color_next;
      sweep_on      <= sweep_on_next;
      sweep_idx     <= sweep_idx_next;
      sweep_data    <= sweep_data_next;
      clearing      <= clearing_next;
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high <= ZERO_HIGH_RST;
      zero_low  <= ZERO_LOW_RST;
      one_high  <= ONE_HIGH_RST;
      one_low   <= ONE_LOW_RST;
      latch_len <= LATCH_RST;
    end else if (cfg.we) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_ZERO_HIGH: zero_high <= cfg.data[TIME_W-1:0];
        CFG_ZERO_LOW:  zero_low  <= cfg.data[TIME_W-1:0];
        CFG_ONE_HIGH:  one_high  <= cfg.data[TIME_W-1:0];
        CFG_ONE_LOW:   one_low   <= cfg.data[TIME_W-1:0];
        CFG_LATCH:     latch_len <= cfg.data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rgbls_checker.sv =====
// ----------------------------------------------------------------------------
// RGB LED serial transmitter checker
// Port-level assertions, bound to the transmitter top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_led_serial_transmitter_assert.svh"

module rgbls_checker import rgbls_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire in_t                   in_data,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire out_t                  out_data,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic unused_ok;

  assign unused_ok = &{1'b0, in_valid, in_data, cfg_we, cfg_index, cfg_wdata};

  `RGBLS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `RGBLS_ASSERT_IMP(a_level_busy, clk, rst, out_valid && out_data.line_level, out_data.busy_res)
  `RGBLS_ASSERT_IMP(a_done_busy, clk, rst, out_valid && out_data.frame_done, out_data.busy_res)
  `RGBLS_ASSERT_IMP(a_done_level, clk, rst, out_valid && out_data.frame_done, !out_data.line_level)
  `RGBLS_ASSERT_NXT(a_clear_after_rst, clk, 1'b0, rst, !in_ready)

endmodule

bind rgb_led_serial_transmitter rgbls_checker u_rgbls_checker (.*);

`default_nettype wire
